/* src/srdm_pkg.sv */
// ----------------------------------------------------------------------------
// srdm_pkg: shared types and constants of the sample rate deviation monitor
// Register indexes, field widths, timing constants, the control state type
// and the handshake between the controller and the bit-serial divider.
// ----------------------------------------------------------------------------
package srdm_pkg;

   // configuration registers
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 26;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL = 1'b1;

   localparam int TARGET_WIDTH   = 20;
   localparam int INTERVAL_WIDTH = 26;
   localparam logic [TARGET_WIDTH-1:0]   TARGET_RESET   = 20'd48000;
   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 26'd1000000;

   // window length: short settings fall back to one second
   localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL_US     = 26'd100000;
   localparam logic [INTERVAL_WIDTH-1:0] DEFAULT_INTERVAL_US = 26'd1000000;
   localparam int LIMIT_NS_WIDTH = 36;
   localparam logic [LIMIT_NS_WIDTH-1:0] NS_PER_US = 36'd1000;

   // frames * 1e9 always fits in 62 bits
   localparam int PRODUCT_WIDTH = 62;
   localparam logic [PRODUCT_WIDTH-1:0] NS_PER_SEC = 62'd1000000000;

   localparam int RATE_WIDTH  = 32;
   localparam int COUNT_WIDTH = 8;
   localparam logic [COUNT_WIDTH-1:0] PERSIST_LIMIT = 8'd4;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = 8'd255;

   localparam logic REQ_REPORT  = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_START,
      ST_DIVIDE,
      ST_BAND,
      ST_REPLY
   } ctrl_state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic saturated;
   } div_status_type;

endpackage

/* src/srdm_if.sv */
// ----------------------------------------------------------------------------
// srdm_if: request and response channels of the sample rate deviation monitor
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface srdm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] frames;
   logic [63:0] timestamp_ns;

   modport source (output valid, output req_type, output frames, output timestamp_ns,
                   input ready);
   modport sink   (input valid, input req_type, input frames, input timestamp_ns,
                   output ready);
endinterface

interface srdm_rsp_if;
   logic        valid;
   logic        ready;
   logic        window_closed;
   logic [31:0] measured_rate_hz;
   logic        out_of_band;
   logic        persistent_alarm;
   logic [7:0]  drift_run;
   logic [31:0] reported_rate_hz;

   modport source (output valid, output window_closed, output measured_rate_hz,
                   output out_of_band, output persistent_alarm, output drift_run,
                   output reported_rate_hz, input ready);
   modport sink   (input valid, input window_closed, input measured_rate_hz,
                   input out_of_band, input persistent_alarm, input drift_run,
                   input reported_rate_hz, output ready);
endinterface

/* src/srdm_div.sv */
// ----------------------------------------------------------------------------
// srdm_div: bit-serial restoring divider
// One quotient bit per cycle; quotients above 32 bits are flagged saturated.
// ----------------------------------------------------------------------------
module srdm_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  srdm_pkg::div_ctrl_type                div_ctrl,
   input  logic [srdm_pkg::PRODUCT_WIDTH-1:0]    dividend,
   input  logic [63:0]                           divisor,
   output srdm_pkg::div_status_type              div_stat,
   output logic [srdm_pkg::RATE_WIDTH-1:0]       quotient
);

   localparam int PW = srdm_pkg::PRODUCT_WIDTH;
   localparam int RW = srdm_pkg::RATE_WIDTH;
   localparam int CW = $clog2(PW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   dsr_ff, dsr_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic          sat_ff, sat_in;

   logic [64:0] trial;
   logic [64:0] diff;
   logic        fits;

   assign trial = {rem_ff, dvd_ff[PW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      if (div_ctrl.start) begin
         busy_in  = 1'b1;
         count_in = CW'(PW - 1);
         rem_in   = '0;
         dsr_in   = divisor;
         dvd_in   = dividend;
         quo_in   = '0;
         sat_in   = 1'b0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         rem_in = fits ? diff[63:0] : trial[63:0];
         dvd_in = {dvd_ff[PW-2:0], 1'b0};
         quo_in = {quo_ff[RW-2:0], fits};
         sat_in = sat_ff | quo_ff[RW-1];
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      sat_ff   <= sat_in;
   end

   assign div_stat.done      = done_ff;
   assign div_stat.saturated = sat_ff;
   assign quotient           = quo_ff;

endmodule

/* src/sample_rate_deviation_monitor_unit.sv */
// ----------------------------------------------------------------------------
// sample_rate_deviation_monitor_unit: audio sample rate watchdog
// Measures frames per second over timed windows and flags persistent drift.
// ----------------------------------------------------------------------------
// Each request word is either a frame report (frames since the last report,
// stamped with a nanosecond time) or a restart. Reports add frames into a
// saturating 32-bit sum; the first report opens a window. When the time since
// the window opened reaches the configured interval, the rate is worked out as
// floor(frames * 1e9 / elapsed_ns), saturated to 32 bits, and tested against
// a band of target/1.04 to target*1.04; consecutive out-of-band windows are
// counted and PERSIST_LIMIT (four by default) or more raise the alarm. Every
// request gives exactly one response word. One request is handled at a time:
// a report that closes a window passes through setup, check, start, the
// 62-step bit-serial divider, the band test and reply; a report that leaves
// the window open goes through setup, check and reply, and a restart through
// setup and reply. The next request is taken the cycle after the response
// word is loaded. A finished response waits in the output register, so the
// next request is taken while it waits; only a second response stalls
// behind it.
// Write the CSRs only while the block is idle.
// ----------------------------------------------------------------------------
module sample_rate_deviation_monitor_unit #(
   parameter logic [srdm_pkg::COUNT_WIDTH-1:0] PERSIST_LIMIT = srdm_pkg::PERSIST_LIMIT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   srdm_req_if.sink                                req_if,
   srdm_rsp_if.source                              rsp_if,
   input  logic                                    csr_we,
   input  logic [srdm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [srdm_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int TW = srdm_pkg::TARGET_WIDTH;
   localparam int IW = srdm_pkg::INTERVAL_WIDTH;
   localparam int LW = srdm_pkg::LIMIT_NS_WIDTH;
   localparam int PW = srdm_pkg::PRODUCT_WIDTH;
   localparam int RW = srdm_pkg::RATE_WIDTH;
   localparam int NW = srdm_pkg::COUNT_WIDTH;

   srdm_pkg::ctrl_state_type state_ff, state_in;

   // configuration
   logic [TW-1:0] target_ff, target_in;
   logic [IW-1:0] interval_ff, interval_in;

   // monitor state
   logic [31:0]   acc_ff, acc_in;
   logic [63:0]   start_ff, start_in;
   logic          open_ff, open_in;
   logic [NW-1:0] dev_ff, dev_in;
   logic [RW-1:0] last_rate_ff, last_rate_in;

   // held request word and working values
   logic          kind_ff, kind_in;
   logic [15:0]   frames_ff, frames_in;
   logic [63:0]   stamp_ff, stamp_in;
   logic [63:0]   elapsed_ff, elapsed_in;
   logic [LW-1:0] limit_ns_ff, limit_ns_in;
   logic [PW-1:0] product_ff, product_in;
   logic          res_closed_ff, res_closed_in;
   logic [RW-1:0] res_rate_ff, res_rate_in;
   logic          res_oob_ff, res_oob_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_closed_ff, rsp_closed_in;
   logic [RW-1:0] rsp_rate_ff, rsp_rate_in;
   logic          rsp_oob_ff, rsp_oob_in;
   logic          rsp_alarm_ff, rsp_alarm_in;
   logic [NW-1:0] rsp_count_ff, rsp_count_in;
   logic [RW-1:0] rsp_shown_ff, rsp_shown_in;

   srdm_pkg::div_ctrl_type   div_ctrl;
   srdm_pkg::div_status_type div_stat;
   logic [RW-1:0]            div_quotient;

   logic [32:0]   sum;
   logic [IW-1:0] interval_eff;
   logic [RW-1:0] rate;
   logic [39:0]   rate_x104, rate_x100, tgt_x100, tgt_x104;
   logic          band_low, band_high;

   srdm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .dividend (product_ff),
      .divisor  (elapsed_ff),
      .div_stat (div_stat),
      .quotient (div_quotient)
   );

   assign sum          = {1'b0, acc_ff} + {17'b0, frames_ff};
   assign interval_eff = (interval_ff > srdm_pkg::MIN_INTERVAL_US)
                         ? interval_ff : srdm_pkg::DEFAULT_INTERVAL_US;

   // clamp quotients that overflow 32 bits
   assign rate      = div_stat.saturated ? '1 : div_quotient;
   assign rate_x104 = {8'b0, rate} * 40'd104;
   assign rate_x100 = {8'b0, rate} * 40'd100;
   assign tgt_x100  = {20'b0, target_ff} * 40'd100;
   assign tgt_x104  = {20'b0, target_ff} * 40'd104;
   assign band_low  = rate_x104 < tgt_x100;
   assign band_high = rate_x100 > tgt_x104;

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      interval_in   = interval_ff;
      acc_in        = acc_ff;
      start_in      = start_ff;
      open_in       = open_ff;
      dev_in        = dev_ff;
      last_rate_in  = last_rate_ff;
      kind_in       = kind_ff;
      frames_in     = frames_ff;
      stamp_in      = stamp_ff;
      elapsed_in    = elapsed_ff;
      limit_ns_in   = limit_ns_ff;
      product_in    = product_ff;
      res_closed_in = res_closed_ff;
      res_rate_in   = res_rate_ff;
      res_oob_in    = res_oob_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_oob_in    = rsp_oob_ff;
      rsp_alarm_in  = rsp_alarm_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_shown_in  = rsp_shown_ff;
      req_if.ready  = 1'b0;
      div_ctrl      = '0;

      if (csr_we && csr_index == srdm_pkg::CSR_TARGET) begin
         target_in = csr_wdata[TW-1:0];
      end
      if (csr_we && csr_index == srdm_pkg::CSR_INTERVAL) begin
         interval_in = csr_wdata[IW-1:0];
      end

      // drop the response word once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         srdm_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               kind_in  = req_if.req_type;
               frames_in = req_if.frames;
               stamp_in = req_if.timestamp_ns;
               state_in = srdm_pkg::ST_SETUP;
            end
         end
         srdm_pkg::ST_SETUP: begin
            limit_ns_in   = {{(LW-IW){1'b0}}, interval_eff} * srdm_pkg::NS_PER_US;
            res_closed_in = 1'b0;
            res_rate_in   = '0;
            res_oob_in    = 1'b0;
            if (kind_ff == srdm_pkg::REQ_RESTART) begin
               // restart: clear frames and count, reopen the window here
               acc_in   = '0;
               dev_in   = '0;
               start_in = stamp_ff;
               open_in  = 1'b1;
               state_in = srdm_pkg::ST_REPLY;
            end else begin
               acc_in = sum[32] ? '1 : sum[31:0];
               if (!open_ff) begin
                  start_in   = stamp_ff;
                  open_in    = 1'b1;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = stamp_ff - start_ff;
               end
               state_in = srdm_pkg::ST_CHECK;
            end
         end
         srdm_pkg::ST_CHECK: begin
            // close the window once a non-zero elapsed time reaches the interval
            if (elapsed_ff != '0 && elapsed_ff >= {{(64-LW){1'b0}}, limit_ns_ff}) begin
               product_in = {{(PW-32){1'b0}}, acc_ff} * srdm_pkg::NS_PER_SEC;
               state_in   = srdm_pkg::ST_START;
            end else begin
               state_in = srdm_pkg::ST_REPLY;
            end
         end
         srdm_pkg::ST_START: begin
            div_ctrl.start = 1'b1;
            state_in       = srdm_pkg::ST_DIVIDE;
         end
         srdm_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = srdm_pkg::ST_BAND;
            end
         end
         srdm_pkg::ST_BAND: begin
            last_rate_in  = rate;
            acc_in        = '0;
            start_in      = stamp_ff;
            res_closed_in = 1'b1;
            res_rate_in   = rate;
            res_oob_in    = band_low | band_high;
            if (band_low | band_high) begin
               if (dev_ff != srdm_pkg::COUNT_MAX) begin
                  dev_in = dev_ff + 1'b1;
               end
            end else begin
               dev_in = '0;
            end
            state_in = srdm_pkg::ST_REPLY;
         end
         srdm_pkg::ST_REPLY: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_closed_in = res_closed_ff;
               rsp_rate_in   = res_rate_ff;
               rsp_oob_in    = res_oob_ff;
               rsp_alarm_in  = res_closed_ff && (dev_ff >= PERSIST_LIMIT);
               rsp_count_in  = dev_ff;
               rsp_shown_in  = (last_rate_ff != '0) ? last_rate_ff
                               : {{(RW-TW){1'b0}}, target_ff};
               state_in      = srdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srdm_pkg::ST_IDLE;
         target_ff    <= srdm_pkg::TARGET_RESET;
         interval_ff  <= srdm_pkg::INTERVAL_RESET;
         acc_ff       <= '0;
         start_ff     <= '0;
         open_ff      <= 1'b0;
         dev_ff       <= '0;
         last_rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         interval_ff  <= interval_in;
         acc_ff       <= acc_in;
         start_ff     <= start_in;
         open_ff      <= open_in;
         dev_ff       <= dev_in;
         last_rate_ff <= last_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      frames_ff     <= frames_in;
      stamp_ff      <= stamp_in;
      elapsed_ff    <= elapsed_in;
      limit_ns_ff   <= limit_ns_in;
      product_ff    <= product_in;
      res_closed_ff <= res_closed_in;
      res_rate_ff   <= res_rate_in;
      res_oob_ff    <= res_oob_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_oob_ff    <= rsp_oob_in;
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_shown_ff  <= rsp_shown_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.window_closed    = rsp_closed_ff;
   assign rsp_if.measured_rate_hz = rsp_rate_ff;
   assign rsp_if.out_of_band      = rsp_oob_ff;
   assign rsp_if.persistent_alarm = rsp_alarm_ff;
   assign rsp_if.drift_run        = rsp_count_ff;
   assign rsp_if.reported_rate_hz = rsp_shown_ff;

endmodule

/* src/srdm_check.sv */
// ----------------------------------------------------------------------------
// srdm_check: response port checks for the sample rate deviation monitor
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module srdm_check #(
   parameter logic [srdm_pkg::COUNT_WIDTH-1:0] PERSIST_LIMIT = srdm_pkg::PERSIST_LIMIT
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        window_closed,
   input logic [31:0] measured_rate_hz,
   input logic        out_of_band,
   input logic        persistent_alarm,
   input logic [7:0]  drift_run,
   input logic [31:0] reported_rate_hz
);

   // a stalled word stays valid and keeps its rates, count and window flag
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(measured_rate_hz)
         && $stable(reported_rate_hz) && $stable(drift_run)
         && $stable(window_closed))
      else $error("response word changed while stalled");

   // without a closed window there is no rate, band flag or alarm
   a_open_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !window_closed |->
         measured_rate_hz == 32'd0 && !out_of_band && !persistent_alarm)
      else $error("window result fields set on a word that closed no window");

   // the alarm needs the count at the limit
   a_alarm_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && persistent_alarm |-> drift_run >= PERSIST_LIMIT)
      else $error("alarm raised below the persistence limit");

   // an out-of-band window always leaves a non-zero count
   a_oob_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && window_closed && out_of_band |-> drift_run != 8'd0)
      else $error("out-of-band window left a zero deviation count");

endmodule

bind sample_rate_deviation_monitor_unit srdm_check #(
   .PERSIST_LIMIT (PERSIST_LIMIT)
) u_srdm_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .window_closed    (rsp_if.window_closed),
   .measured_rate_hz (rsp_if.measured_rate_hz),
   .out_of_band      (rsp_if.out_of_band),
   .persistent_alarm (rsp_if.persistent_alarm),
   .drift_run        (rsp_if.drift_run),
   .reported_rate_hz (rsp_if.reported_rate_hz)
);

/* tb/sv/sample_rate_deviation_monitor_unit_tb.sv */
// ----------------------------------------------------------------------------
// sample_rate_deviation_monitor_unit_tb: self-checking bench for the monitor
// Drives frame reports and restarts through the request channel, keeps its
// own model of the window, rate and deviation logic, and checks every
// response word field by field, mostly under random stalls on both channels.
// ----------------------------------------------------------------------------
module sample_rate_deviation_monitor_unit_tb;

   // run guard: a run that reaches this cycle count ends as failed
   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          SHOWN_ERRORS  = 10;
   // drain time after the last response, so stray words can show
   localparam int          DRAIN_CYCLES  = 80;
   localparam logic [63:0] NS_PER_SECOND = 64'd1_000_000_000;
   localparam logic [63:0] NS_IN_US      = 64'd1_000;
   localparam logic [63:0] FLOOR_US      = 64'd100_000;
   localparam logic [63:0] FALLBACK_US   = 64'd1_000_000;
   localparam logic [63:0] RATE_CEILING  = 64'hFFFF_FFFF;
   localparam logic [63:0] BAND_WIDE     = 64'd104;
   localparam logic [63:0] BAND_BASE     = 64'd100;
   localparam logic [7:0]  ALARM_RUN     = 8'd4;
   localparam logic [7:0]  RUN_CAP       = 8'd255;

   typedef struct packed {
      logic        window_closed;
      logic [31:0] measured_rate_hz;
      logic        out_of_band;
      logic        persistent_alarm;
      logic [7:0]  drift_run;
      logic [31:0] reported_rate_hz;
   } rate_report_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] frames;
      logic [63:0] stamp;
   } report_word_type;

   // how far a burst of windows sits from the target
   typedef enum int unsigned {
      DRIFT_NONE,
      DRIFT_SLOW,
      DRIFT_FAST,
      DRIFT_EDGE
   } drift_kind_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_we;
   logic [srdm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [srdm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   srdm_req_if req_ch ();
   srdm_rsp_if rsp_ch ();

   sample_rate_deviation_monitor_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model copy of the registers and the window state
   logic [srdm_pkg::TARGET_WIDTH-1:0]   cfg_target_hz;
   logic [srdm_pkg::INTERVAL_WIDTH-1:0] cfg_interval_us;
   logic [31:0]                         frame_sum;
   logic [63:0]                         window_base_ns;
   logic                                window_live;
   logic [7:0]                          run_length;
   logic [31:0]                         last_rate_hz;

   // words waiting to go out, and responses owed by the block
   report_word_type req_backlog[$];
   rate_report_type pending_reports[$];

   logic [63:0] stamp_ns;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          cycle_count;
   int          words_queued;
   int          words_taken;
   int          windows_seen;
   int          alarms_seen;
   int          peak_run;
   int          mismatch_count;
   int          stray_count;

   // -------------------------------------------------------------------------
   // model of the monitor: one request word in, the expected response out
   // -------------------------------------------------------------------------
   function automatic logic [63:0] window_length_ns();
      logic [63:0] span_us;
      span_us = (64'(cfg_interval_us) > FLOOR_US) ? 64'(cfg_interval_us) : FALLBACK_US;
      return span_us * NS_IN_US;
   endfunction

   function automatic rate_report_type compute_rate_report(input logic kind,
                                                           input logic [15:0] frames,
                                                           input logic [63:0] stamp);
      rate_report_type r;
      logic [32:0]     sum;
      logic [63:0]     elapsed;
      logic [63:0]     rate;
      r = '0;
      if (kind == srdm_pkg::REQ_RESTART) begin
         // frames field plays no part; the last rate survives
         frame_sum      = '0;
         run_length     = '0;
         window_base_ns = stamp;
         window_live    = 1'b1;
      end else begin
         if (!window_live) begin
            window_base_ns = stamp;
            window_live    = 1'b1;
         end
         sum       = {1'b0, frame_sum} + 33'(frames);
         frame_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         // backwards time wraps round to a huge elapsed value
         elapsed = stamp - window_base_ns;
         if (elapsed != 64'd0 && elapsed >= window_length_ns()) begin
            rate = (64'(frame_sum) * NS_PER_SECOND) / elapsed;
            if (rate > RATE_CEILING) rate = RATE_CEILING;
            last_rate_hz       = rate[31:0];
            frame_sum          = '0;
            window_base_ns     = stamp;
            r.window_closed    = 1'b1;
            r.measured_rate_hz = rate[31:0];
            if (rate * BAND_WIDE < 64'(cfg_target_hz) * BAND_BASE ||
                rate * BAND_BASE > 64'(cfg_target_hz) * BAND_WIDE) begin
               r.out_of_band = 1'b1;
               if (run_length < RUN_CAP) run_length = run_length + 8'd1;
            end else begin
               run_length = '0;
            end
            r.persistent_alarm = (run_length >= ALARM_RUN);
         end
      end
      r.drift_run        = run_length;
      // a zero rate reads back as the target
      r.reported_rate_hz = (last_rate_hz != 32'd0) ? last_rate_hz : 32'(cfg_target_hz);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // clock, cycle count and run guard
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : run_guard
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses still owed",
               cycle_count, pending_reports.size());
      $display("** sample_rate_deviation_monitor_unit: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // request side: present the backlog head, predict on every accepted word
   // -------------------------------------------------------------------------
   initial begin : request_driver
      req_ch.valid        = 1'b0;
      req_ch.req_type     = srdm_pkg::REQ_REPORT;
      req_ch.frames       = '0;
      req_ch.timestamp_ns = '0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            // take the word the block accepted at this edge
            if (req_ch.valid && req_ch.ready) begin
               pending_reports.push_back(compute_rate_report(req_ch.req_type, req_ch.frames,
                                                             req_ch.timestamp_ns));
               void'(req_backlog.pop_front());
               words_taken++;
            end
            // hold a word that is still waiting; otherwise offer the next or idle
            if (!req_ch.valid || req_ch.ready) begin
               if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                  req_ch.valid        <= 1'b1;
                  req_ch.req_type     <= req_backlog[0].kind;
                  req_ch.frames       <= req_backlog[0].frames;
                  req_ch.timestamp_ns <= req_backlog[0].stamp;
               end else begin
                  req_ch.valid <= 1'b0;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // response side: random stalls, compare each word with the oldest prediction
   // -------------------------------------------------------------------------
   initial begin : report_checker
      rate_report_type seen;
      rate_report_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               seen.window_closed    = rsp_ch.window_closed;
               seen.measured_rate_hz = rsp_ch.measured_rate_hz;
               seen.out_of_band      = rsp_ch.out_of_band;
               seen.persistent_alarm = rsp_ch.persistent_alarm;
               seen.drift_run        = rsp_ch.drift_run;
               seen.reported_rate_hz = rsp_ch.reported_rate_hz;
               if (pending_reports.size() == 0) begin
                  stray_count++;
                  if (mismatch_count + stray_count <= SHOWN_ERRORS)
                     $display("cycle %0d: response word with no request outstanding",
                              cycle_count);
               end else begin
                  want = pending_reports.pop_front();
                  if (seen.window_closed    !== want.window_closed    ||
                      seen.measured_rate_hz !== want.measured_rate_hz ||
                      seen.out_of_band      !== want.out_of_band      ||
                      seen.persistent_alarm !== want.persistent_alarm ||
                      seen.drift_run        !== want.drift_run        ||
                      seen.reported_rate_hz !== want.reported_rate_hz) begin
                     mismatch_count++;
                     if (mismatch_count + stray_count <= SHOWN_ERRORS) begin
                        $display("cycle %0d mismatch, expected: closed=%0b rate=%0d oob=%0b",
                                 cycle_count, want.window_closed, want.measured_rate_hz,
                                 want.out_of_band);
                        $display("   alarm=%0b count=%0d shown=%0d", want.persistent_alarm,
                                 want.drift_run, want.reported_rate_hz);
                        $display("   actual: closed=%0b rate=%0d oob=%0b alarm=%0b",
                                 seen.window_closed, seen.measured_rate_hz,
                                 seen.out_of_band, seen.persistent_alarm);
                        $display("   count=%0d shown=%0d", seen.drift_run,
                                 seen.reported_rate_hz);
                     end
                  end
               end
               windows_seen += int'(seen.window_closed);
               alarms_seen  += int'(seen.persistent_alarm);
               if (int'(seen.drift_run) > peak_run) peak_run = int'(seen.drift_run);
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // shared stimulus tasks
   // -------------------------------------------------------------------------
   // queue one word; keep at most two ahead so the driver never runs dry
   task automatic send_word(input logic kind, input logic [15:0] frames,
                            input logic [63:0] stamp);
      report_word_type word;
      word.kind   = kind;
      word.frames = frames;
      word.stamp  = stamp;
      req_backlog.push_back(word);
      words_queued++;
      while (req_backlog.size() > 2) @(posedge clock);
   endtask

   // every word sent has been answered, so the block sits idle
   task automatic wait_idle;
      while (req_backlog.size() != 0 || pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [srdm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [srdm_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == srdm_pkg::CSR_TARGET) cfg_target_hz = value[srdm_pkg::TARGET_WIDTH-1:0];
      else cfg_interval_us = value[srdm_pkg::INTERVAL_WIDTH-1:0];
   endtask

   task automatic program_monitor(input logic [srdm_pkg::TARGET_WIDTH-1:0] target_hz,
                                  input logic [srdm_pkg::INTERVAL_WIDTH-1:0] interval_us);
      wait_idle();
      write_csr(srdm_pkg::CSR_TARGET, srdm_pkg::CSR_DATA_WIDTH'(target_hz));
      write_csr(srdm_pkg::CSR_INTERVAL, srdm_pkg::CSR_DATA_WIDTH'(interval_us));
   endtask

   function automatic logic [63:0] pick_rate(input drift_kind_type drift);
      logic [63:0] t;
      t = 64'(cfg_target_hz);
      case (drift)
         DRIFT_NONE: return t * (97 + $urandom_range(0, 6)) / 100;
         DRIFT_SLOW: return t * $urandom_range(0, 92) / 100;
         DRIFT_FAST: return t * $urandom_range(106, 200) / 100;
         default:    return ($urandom_range(1) ? t * 100 / 104 : t * 104 / 100)
                            + $urandom_range(0, 1);
      endcase
   endfunction

   // one window's worth of reports at roughly the given rate; the last report
   // always reaches the interval, jitter may close it a report early
   task automatic send_window(input logic [63:0] rate);
      logic [63:0] span;
      logic [63:0] step;
      logic [63:0] stride;
      logic [63:0] frames_wide;
      int          reports;
      span    = window_length_ns();
      reports = int'(rate * span / NS_PER_SECOND / 64'd65535) + 1 + $urandom_range(0, 3);
      if (reports > 12) reports = 12;
      step = span / 64'(reports) + 64'd1;
      repeat (reports) begin
         stride      = step + step * $urandom_range(0, 10) / 100;
         stamp_ns    += stride;
         frames_wide = rate * stride / NS_PER_SECOND + $urandom_range(0, 1);
         if (frames_wide > 64'hFFFF) frames_wide = 64'hFFFF;
         send_word(srdm_pkg::REQ_REPORT, frames_wide[15:0], stamp_ns);
      end
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // no register written yet: the reset target and one second interval apply
   task automatic test_power_on_defaults;
      send_word(srdm_pkg::REQ_REPORT, 16'd100, 64'd0);
      send_word(srdm_pkg::REQ_REPORT, 16'd47_000, NS_PER_SECOND);
      stamp_ns = NS_PER_SECOND;
   endtask

   // band limits at 48 kHz, then four bad windows in a row to raise the alarm
   task automatic test_band_edges;
      logic [15:0] frame_plan [0:7];
      frame_plan = '{16'd48_000, 16'd46_154, 16'd46_153, 16'd49_920,
                     16'd49_921, 16'hFFFF, 16'd0, 16'hFFFF};
      program_monitor(20'd48_000, 26'd1_000_000);
      send_word(srdm_pkg::REQ_RESTART, 16'd0, stamp_ns);
      // every window is exactly one interval long
      foreach (frame_plan[i]) begin
         stamp_ns += NS_PER_SECOND;
         send_word(srdm_pkg::REQ_REPORT, frame_plan[i], stamp_ns);
      end
      send_word(srdm_pkg::REQ_RESTART, 16'd0, stamp_ns);
   endtask

   // zero elapsed, just short of the interval, time running backwards,
   // wrap through the top of the time range and a zero timestamp
   task automatic test_time_corners;
      send_word(srdm_pkg::REQ_REPORT, 16'd100, stamp_ns);
      send_word(srdm_pkg::REQ_REPORT, 16'd200, stamp_ns + NS_PER_SECOND - 64'd1);
      send_word(srdm_pkg::REQ_REPORT, 16'd5, 64'd3);
      send_word(srdm_pkg::REQ_RESTART, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(srdm_pkg::REQ_REPORT, 16'hFFFF, 64'd0);
      send_word(srdm_pkg::REQ_REPORT, 16'd0, NS_PER_SECOND - 64'd1);
      send_word(srdm_pkg::REQ_RESTART, 16'd0, 64'd0);
      send_word(srdm_pkg::REQ_REPORT, 16'd0, 64'd0);
      stamp_ns = 64'd0;
   endtask

   // zero target puts every non-zero rate out of band: run the count past its cap
   task automatic test_deviation_count_saturation;
      program_monitor(20'd0, 26'd0);
      send_word(srdm_pkg::REQ_RESTART, 16'($urandom), stamp_ns);
      repeat (265) begin
         stamp_ns += window_length_ns() + 64'($urandom_range(0, 999));
         send_word(srdm_pkg::REQ_REPORT, 16'($urandom_range(2, 65535)), stamp_ns);
      end
      // an empty window sits inside a zero band and clears the run
      stamp_ns += window_length_ns();
      send_word(srdm_pkg::REQ_REPORT, 16'd0, stamp_ns);
   endtask

   // pile full reports onto one timestamp, then close over the shortest
   // interval for a rate far above the target
   task automatic test_heavy_window;
      program_monitor(20'd1_000_000, 26'd100_001);
      send_word(srdm_pkg::REQ_RESTART, 16'd0, stamp_ns);
      repeat (40) send_word(srdm_pkg::REQ_REPORT, 16'hFFFF, stamp_ns);
      stamp_ns += window_length_ns();
      send_word(srdm_pkg::REQ_REPORT, 16'd0, stamp_ns);
   endtask

   // mostly bursts of well-formed windows, with restarts, stalled clocks,
   // random frame counts and wild timestamps mixed in
   task automatic test_random_traffic(input logic [srdm_pkg::TARGET_WIDTH-1:0] target_hz,
                                      input logic [srdm_pkg::INTERVAL_WIDTH-1:0] interval_us,
                                      input int word_budget);
      int             first_word;
      int             windows;
      drift_kind_type drift;
      program_monitor(target_hz, interval_us);
      first_word = words_queued;
      while (words_queued - first_word < word_budget) begin
         case ($urandom_range(19))
            0, 1: send_word(srdm_pkg::REQ_RESTART, 16'($urandom), stamp_ns);
            2, 3: begin
               stamp_ns += 64'($urandom_range(0, 3)) * 64'($urandom_range(0, 50_000_000));
               send_word(srdm_pkg::REQ_REPORT, 16'($urandom), stamp_ns);
            end
            4: begin
               stamp_ns = {$urandom, $urandom};
               send_word(srdm_pkg::REQ_REPORT, 16'($urandom), stamp_ns);
            end
            default: begin
               drift = drift_kind_type'($urandom_range(3));
               if ($urandom_range(3) == 0)
                  send_word(srdm_pkg::REQ_RESTART, 16'($urandom), stamp_ns);
               windows = $urandom_range(1, 6);
               repeat (windows) send_window(pick_rate(drift));
            end
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin : test_sequence
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = srdm_pkg::CSR_TARGET;
      csr_wdata      = '0;
      cfg_target_hz  = 20'd48_000;
      cfg_interval_us = 26'd1_000_000;
      frame_sum      = '0;
      window_base_ns = '0;
      window_live    = 1'b0;
      run_length     = '0;
      last_rate_hz   = '0;
      stamp_ns       = '0;
      words_queued   = 0;
      words_taken    = 0;
      windows_seen   = 0;
      alarms_seen    = 0;
      peak_run       = 0;
      mismatch_count = 0;
      stray_count    = 0;
      // sender idles lightly, receiver stalls heavily
      send_idle_pct  = 12;
      recv_stall_pct = 47;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_power_on_defaults();
      test_band_edges();
      test_time_corners();
      test_random_traffic(20'd48_000, 26'd1_000_000, 120);
      test_deviation_count_saturation();

      // swap the pressure round: sender starves, receiver mostly keeps up
      send_idle_pct  = 47;
      recv_stall_pct = 12;
      test_random_traffic(20'd1_000_000, 26'd100_001, 120);
      test_random_traffic(20'd44_100, 26'd100_000, 120);

      // full speed on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_heavy_window();
      test_random_traffic(20'd1_000, 26'd60_000_000, 120);
      test_random_traffic(20'd1, 26'd250_000, 120);

      // drain, then give any stray response time to show itself
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words across six register settings, %0d windows closed",
               words_taken, windows_seen);
      $display("alarm on %0d responses, longest out-of-band run %0d, %0d bad, %0d stray",
               alarms_seen, peak_run, mismatch_count, stray_count);
      if (mismatch_count == 0 && stray_count == 0 && pending_reports.size() == 0) begin
         $display("** sample_rate_deviation_monitor_unit: PASSED **");
      end else begin
         $display("** sample_rate_deviation_monitor_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/srdm_pkg.sv
src/srdm_if.sv
src/srdm_div.sv
src/sample_rate_deviation_monitor_unit.sv
src/srdm_check.sv
tb/sv/sample_rate_deviation_monitor_unit_tb.sv
